// ===== design/rqi_pkg.sv =====
// Shared constants for the ray against convex quad intersection block.
// No dependencies; used by rqi_lane, ray_quad_intersect and rqi_checker.
package rqi_pkg;
  localparam int unsigned COORD_WIDTH_DEF    = 24;
  localparam int unsigned TIME_FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_EDGES          = 4;
  localparam int unsigned NUM_IN_FIELDS      = 12;
  localparam int unsigned TOL_WIDTH          = 16;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;
  localparam int unsigned LANE_STAGES_FIXED  = 8;
endpackage

// ===== design/rqi_lane.sv =====
// One edge test lane: inward normal, entry test, bit-per-stage division, edge projection.
// Depends on rqi_pkg; instantiated four times by ray_quad_intersect.
module rqi_lane #(
  parameter int unsigned COORD_WIDTH    = rqi_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TIME_FRAC_BITS = rqi_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [COORD_WIDTH-1:0]       px_i,
  input  logic signed [COORD_WIDTH-1:0]       py_i,
  input  logic signed [COORD_WIDTH-1:0]       dx_i,
  input  logic signed [COORD_WIDTH-1:0]       dy_i,
  input  logic signed [COORD_WIDTH-1:0]       ax_i,
  input  logic signed [COORD_WIDTH-1:0]       ay_i,
  input  logic signed [COORD_WIDTH-1:0]       bx_i,
  input  logic signed [COORD_WIDTH-1:0]       by_i,
  input  logic signed [COORD_WIDTH+1:0]       sx_i,
  input  logic signed [COORD_WIDTH+1:0]       sy_i,
  input  logic [rqi_pkg::TOL_WIDTH-1:0]       tol_i,
  output logic                                hit_o,
  output logic [TIME_FRAC_BITS-1:0]           tq_o,
  output logic signed [COORD_WIDTH:0]         nx_o,
  output logic signed [COORD_WIDTH:0]         ny_o
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned TF = TIME_FRAC_BITS;
  localparam int unsigned WD = 2 * CW + 2;
  localparam int unsigned WN = 2 * CW + 3;
  localparam int unsigned WS = 2 * CW + 4;
  localparam int unsigned WL = WD + rqi_pkg::TOL_WIDTH;
  localparam int unsigned WV = 2 * CW + 22;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW:0]   lx;
    logic signed [CW:0]   ly;
    logic signed [CW:0]   nx;
    logic signed [CW:0]   ny;
    logic [WD-1:0]        l2;
    logic                 cand;
    logic [WD-1:0]        rem;
    logic [WD-1:0]        den;
    logic [TF-1:0]        tq;
  } div_t;

  // stage A
  logic signed [CW:0]   nrx_q, nry_q, rx_q, ry_q, lx_q, ly_q;
  logic signed [CW+2:0] ox_q, oy_q;
  logic signed [CW-1:0] pxa_q, pya_q, dxa_q, dya_q, axa_q, aya_q;
  // stage B
  logic signed [2*CW+3:0] po1_q, po2_q;
  logic signed [2*CW:0]   pd1_q, pd2_q;
  logic signed [2*CW+1:0] pn1_q, pn2_q, pl1_q, pl2_q;
  logic signed [CW:0]     nrxb_q, nryb_q, lxb_q, lyb_q;
  logic signed [CW-1:0]   pxb_q, pyb_q, dxb_q, dyb_q, axb_q, ayb_q;
  // stage C and division
  div_t div_q [TF+1];
  div_t div_d [TF+1];
  logic signed [WS:0]   orient;
  logic signed [WN-1:0] den0, num0, den_s, num_s;
  logic                 neg;
  // stage E..I
  logic signed [TF+CW:0]  mx_q, my_q;
  logic signed [TF+CW:0]  shx, shy;
  logic signed [CW+1:0]   dqx_q, dqy_q;
  logic signed [2*CW+2:0] s1_q, s2_q;
  logic signed [WS-1:0]   s_q;
  logic [WL-1:0]          lt_q;
  logic signed [WV-1:0]   lowv, highv;
  div_t e_q, f_q, g_q, h_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nrx_q <= (CW+1)'(by_i) - (CW+1)'(ay_i);
      nry_q <= (CW+1)'(ax_i) - (CW+1)'(bx_i);
      lx_q  <= (CW+1)'(bx_i) - (CW+1)'(ax_i);
      ly_q  <= (CW+1)'(by_i) - (CW+1)'(ay_i);
      rx_q  <= (CW+1)'(ax_i) - (CW+1)'(px_i);
      ry_q  <= (CW+1)'(ay_i) - (CW+1)'(py_i);
      ox_q  <= ((CW+3)'(bx_i) <<< 2) - (CW+3)'(sx_i);
      oy_q  <= ((CW+3)'(by_i) <<< 2) - (CW+3)'(sy_i);
      pxa_q <= px_i; pya_q <= py_i; dxa_q <= dx_i; dya_q <= dy_i;
      axa_q <= ax_i; aya_q <= ay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      po1_q <= (2*CW+4)'(nrx_q * ox_q);
      po2_q <= (2*CW+4)'(nry_q * oy_q);
      pd1_q <= (2*CW+1)'(dxa_q * nrx_q);
      pd2_q <= (2*CW+1)'(dya_q * nry_q);
      pn1_q <= (2*CW+2)'(rx_q * nrx_q);
      pn2_q <= (2*CW+2)'(ry_q * nry_q);
      pl1_q <= (2*CW+2)'(nrx_q * nrx_q);
      pl2_q <= (2*CW+2)'(nry_q * nry_q);
      nrxb_q <= nrx_q; nryb_q <= nry_q; lxb_q <= lx_q; lyb_q <= ly_q;
      pxb_q <= pxa_q; pyb_q <= pya_q; dxb_q <= dxa_q; dyb_q <= dya_q;
      axb_q <= axa_q; ayb_q <= aya_q;
    end
  end

  always_comb begin
    logic [WD:0] r2;
    logic        ge;
    orient = (WS+1)'(po1_q) + (WS+1)'(po2_q);
    neg    = orient > 0;
    den0   = WN'(pd1_q) + WN'(pd2_q);
    num0   = WN'(pn1_q) + WN'(pn2_q);
    den_s  = neg ? -den0 : den0;
    num_s  = neg ? -num0 : num0;
    div_d[0].px   = pxb_q;
    div_d[0].py   = pyb_q;
    div_d[0].dx   = dxb_q;
    div_d[0].dy   = dyb_q;
    div_d[0].ax   = axb_q;
    div_d[0].ay   = ayb_q;
    div_d[0].lx   = lxb_q;
    div_d[0].ly   = lyb_q;
    div_d[0].nx   = neg ? -nrxb_q : nrxb_q;
    div_d[0].ny   = neg ? -nryb_q : nryb_q;
    div_d[0].l2   = WD'(pl1_q) + WD'(pl2_q);
    div_d[0].cand = (den_s > 0) && (num_s >= 0) && (num_s < den_s);
    div_d[0].rem  = WD'(num_s);
    div_d[0].den  = WD'(den_s);
    div_d[0].tq   = '0;
    for (int k = 1; k <= TF; k++) begin
      r2 = {div_q[k-1].rem, 1'b0};
      ge = r2 >= {1'b0, div_q[k-1].den};
      div_d[k]     = div_q[k-1];
      div_d[k].rem = ge ? WD'(r2 - {1'b0, div_q[k-1].den}) : WD'(r2);
      div_d[k].tq  = {div_q[k-1].tq[TF-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= TF; k++) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  assign shx = mx_q >>> TF;
  assign shy = my_q >>> TF;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q  <= (TF+CW+1)'($signed({1'b0, div_q[TF].tq}) * div_q[TF].dx);
      my_q  <= (TF+CW+1)'($signed({1'b0, div_q[TF].tq}) * div_q[TF].dy);
      e_q   <= div_q[TF];
      dqx_q <= (CW+2)'(shx) + (CW+2)'(e_q.px) - (CW+2)'(e_q.ax);
      dqy_q <= (CW+2)'(shy) + (CW+2)'(e_q.py) - (CW+2)'(e_q.ay);
      f_q   <= e_q;
      s1_q  <= (2*CW+3)'(dqx_q * f_q.lx);
      s2_q  <= (2*CW+3)'(dqy_q * f_q.ly);
      g_q   <= f_q;
      s_q   <= WS'(s1_q) + WS'(s2_q);
      lt_q  <= WL'(g_q.l2 * tol_i);
      h_q   <= g_q;
    end
  end

  assign lowv  = (WV'(s_q) <<< 16) + WV'(lt_q);
  assign highv = (WV'({1'b0, h_q.l2}) <<< 16) + WV'(lt_q) - (WV'(s_q) <<< 16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= h_q.cand && (lowv >= 0) && (highv >= 0);
      tq_o  <= h_q.tq;
      nx_o  <= h_q.nx;
      ny_o  <= h_q.ny;
    end
  end
endmodule

// ===== design/ray_quad_intersect.sv =====
// Top level of the ray segment against convex quad intersection block.
// Depends on rqi_pkg and rqi_lane; four lanes test the edges, a merge picks the earliest hit.
//
//  channel  dir  fields (low bit up)
//  s_*      in   origin_x, origin_y, ray_dx, ray_dy, corner0_x .. corner3_y
//  m_*      out  tdata: hit_time, normal_x, normal_y, edge_index; tuser: hit
//  cfg_*    in   edge_tolerance
//
// One request per cycle unless the output stalls; each request passes through the
// lanes, with their bit-per-stage dividers, and a registered merge. Reset clears
// the valid chain and sets edge_tolerance to 1. A stall on m_tready_i freezes the
// whole pipeline.
module ray_quad_intersect #(
  parameter int unsigned COORD_WIDTH    = rqi_pkg::COORD_WIDTH_DEF,
  parameter int unsigned TIME_FRAC_BITS = rqi_pkg::TIME_FRAC_BITS_DEF,
  localparam int unsigned IN_W  = ((rqi_pkg::NUM_IN_FIELDS * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_B = TIME_FRAC_BITS + 2 * (COORD_WIDTH + 1) + 2,
  localparam int unsigned OUT_W = ((OUT_B + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // origin_x, origin_y, ray_dx, ray_dy, corner0_x, corner0_y, .., corner3_y
  input  logic [IN_W-1:0]                 s_tdata_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // hit_time, normal_x, normal_y, edge_index
  output logic [OUT_W-1:0]                m_tdata_o,
  // hit
  output logic                            m_tuser_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rqi_pkg::TOL_WIDTH-1:0]   cfg_data_i
);
  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned TF    = TIME_FRAC_BITS;
  localparam int unsigned NE    = rqi_pkg::NUM_EDGES;
  localparam int unsigned DEPTH = TF + rqi_pkg::LANE_STAGES_FIXED + 1;

  logic [DEPTH-1:0] vld_q, vld_d;
  logic             en;
  logic [rqi_pkg::TOL_WIDTH-1:0] tol_q;

  logic signed [CW-1:0] px, py, dx, dy;
  logic signed [CW-1:0] cx [NE];
  logic signed [CW-1:0] cy [NE];
  logic signed [CW+1:0] sx, sy;

  logic              l_hit [NE];
  logic [TF-1:0]     l_tq  [NE];
  logic signed [CW:0] l_nx [NE];
  logic signed [CW:0] l_ny [NE];

  logic              hit_d, hit_q;
  logic [TF-1:0]     t_d, t_q;
  logic signed [CW:0] nx_d, ny_d, nx_q, ny_q;
  logic [1:0]        e_d, e_q;

  assign en          = !vld_q[DEPTH-1] || m_tready_i;
  assign s_tready_o  = en;
  assign m_tvalid_o  = vld_q[DEPTH-1];
  assign cfg_ready_o = 1'b1;
  assign vld_d       = {vld_q[DEPTH-2:0], s_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      tol_q <= rqi_pkg::TOL_RESET;
    end else begin
      if (en) vld_q <= vld_d;
      if (cfg_valid_i) tol_q <= cfg_data_i;
    end
  end

  assign px = s_tdata_i[0*CW +: CW];
  assign py = s_tdata_i[1*CW +: CW];
  assign dx = s_tdata_i[2*CW +: CW];
  assign dy = s_tdata_i[3*CW +: CW];

  always_comb begin
    sx = '0;
    sy = '0;
    for (int i = 0; i < NE; i++) begin
      cx[i] = s_tdata_i[(4 + 2 * i) * CW +: CW];
      cy[i] = s_tdata_i[(5 + 2 * i) * CW +: CW];
      sx    = sx + (CW+2)'(cx[i]);
      sy    = sy + (CW+2)'(cy[i]);
    end
  end

  for (genvar g = 0; g < NE; g++) begin : g_lane
    rqi_lane #(
      .COORD_WIDTH   (COORD_WIDTH),
      .TIME_FRAC_BITS(TIME_FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .px_i  (px),
      .py_i  (py),
      .dx_i  (dx),
      .dy_i  (dy),
      .ax_i  (cx[g]),
      .ay_i  (cy[g]),
      .bx_i  (cx[(g + 1) % NE]),
      .by_i  (cy[(g + 1) % NE]),
      .sx_i  (sx),
      .sy_i  (sy),
      .tol_i (tol_q),
      .hit_o (l_hit[g]),
      .tq_o  (l_tq[g]),
      .nx_o  (l_nx[g]),
      .ny_o  (l_ny[g])
    );
  end

  always_comb begin
    hit_d = 1'b0;
    t_d   = '1;
    nx_d  = '0;
    ny_d  = '0;
    e_d   = '0;
    for (int i = 0; i < NE; i++) begin
      if (l_hit[i] && (!hit_d || l_tq[i] < t_d)) begin
        hit_d = 1'b1;
        t_d   = l_tq[i];
        nx_d  = l_nx[i];
        ny_d  = l_ny[i];
        e_d   = 2'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
      t_q   <= t_d;
      nx_q  <= nx_d;
      ny_q  <= ny_d;
      e_q   <= e_d;
    end
  end

  assign m_tuser_o = hit_q;
  assign m_tdata_o = OUT_W'({e_q, ny_q, nx_q, t_q});

  a_miss_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o |-> m_tdata_o[TF-1:0] == {TF{1'b1}})
    else $error("miss without all-ones time");

  a_hit_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> (nx_q != 0) || (ny_q != 0))
    else $error("hit with zero normal");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid chain moved during stall");
endmodule

// ===== bench/rqi_checker.sv =====
// Checker for ray_quad_intersect: watches the input, output and tolerance channels.
// Predicts each result from the accepted request and compares it field by field.
// Depends on rqi_pkg for the tolerance width and reset value.
`timescale 1ns / 1ps

module rqi_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [287:0]                  s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [71:0]                   m_tdata_i,
  input  logic                          m_tuser_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rqi_pkg::TOL_WIDTH-1:0] cfg_data_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            hits_o
);
  typedef struct packed {
    logic        hit;
    logic [15:0] hit_time;
    logic [24:0] normal_x;
    logic [24:0] normal_y;
    logic [1:0]  edge_index;
  } hit_rec_t;

  typedef logic signed [127:0] wide_t;

  hit_rec_t                      hits_due[$];
  logic [rqi_pkg::TOL_WIDTH-1:0] tol;
  int                            n_err = 0;
  int                            n_hit = 0;
  int                            n_pend = 0;

  function automatic wide_t fld(logic [287:0] d, int k);
    logic signed [23:0] v;
    v = d[24*k +: 24];
    return wide_t'(v);
  endfunction

  function automatic hit_rec_t cross_quad(logic [287:0] d, logic [15:0] tl);
    hit_rec_t r;
    wide_t px, py, dx, dy, sx, sy, ax, ay, bx, by, nx, ny, lx, ly;
    wide_t den, num, qx, qy, s, l2, lowv, highv, tw;
    wide_t cx[4], cy[4];
    logic [15:0] tq;
    logic found;
    found = 1'b0;
    r = '0;
    r.hit_time = '1;
    px = fld(d, 0); py = fld(d, 1); dx = fld(d, 2); dy = fld(d, 3);
    sx = 0; sy = 0;
    for (int i = 0; i < 4; i++) begin
      cx[i] = fld(d, 4 + 2 * i);
      cy[i] = fld(d, 5 + 2 * i);
      sx += cx[i];
      sy += cy[i];
    end
    for (int i = 0; i < 4; i++) begin
      ax = cx[i]; ay = cy[i]; bx = cx[(i + 1) % 4]; by = cy[(i + 1) % 4];
      nx = by - ay; ny = ax - bx;
      lx = bx - ax; ly = by - ay;
      if (nx * (4 * bx - sx) + ny * (4 * by - sy) > 0) begin
        nx = -nx; ny = -ny;
      end
      den = dx * nx + dy * ny;
      if (den <= 0) continue;
      num = (ax - px) * nx + (ay - py) * ny;
      if (num < 0 || num >= den) continue;
      tq = 16'((num <<< 16) / den);
      tw = wide_t'({112'd0, tq});
      qx = px + ((tw * dx) >>> 16);
      qy = py + ((tw * dy) >>> 16);
      s  = (qx - ax) * lx + (qy - ay) * ly;
      l2 = lx * lx + ly * ly;
      lowv  = s * 65536 + l2 * wide_t'({112'd0, tl});
      highv = l2 * (65536 + wide_t'({112'd0, tl})) - s * 65536;
      if (lowv < 0 || highv < 0) continue;
      if (!found || tq < r.hit_time) begin
        found = 1'b1;
        r.hit = 1'b1;
        r.hit_time = tq;
        r.normal_x = nx[24:0];
        r.normal_y = ny[24:0];
        r.edge_index = 2'(i);
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    n_err++;
  endtask

  assign errors_o  = n_err;
  assign hits_o    = n_hit;
  assign pending_o = n_pend;

  always @(posedge clk_i or negedge rst_ni) begin
    hit_rec_t w;
    if (!rst_ni) begin
      tol <= rqi_pkg::TOL_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_i) tol <= cfg_data_i;
      if (s_tvalid_i && s_tready_i) hits_due.push_back(cross_quad(s_tdata_i, tol));
      if (m_tvalid_i && m_tready_i) begin
        if (hits_due.size() == 0) begin
          report("unexpected result", m_tdata_i[31:0], 0);
        end else begin
          w = hits_due.pop_front();
          if (w.hit) n_hit++;
          if (m_tuser_i !== w.hit) report("hit", m_tuser_i, w.hit);
          if (m_tdata_i[15:0] !== w.hit_time) report("hit_time", m_tdata_i[15:0], w.hit_time);
          if (m_tdata_i[40:16] !== w.normal_x) report("normal_x", m_tdata_i[40:16], w.normal_x);
          if (m_tdata_i[65:41] !== w.normal_y) report("normal_y", m_tdata_i[65:41], w.normal_y);
          if (m_tdata_i[67:66] !== w.edge_index)
            report("edge_index", m_tdata_i[67:66], w.edge_index);
        end
      end
      n_pend = hits_due.size();
    end
  end
endmodule

// ===== bench/tb.sv =====
// Testbench top for ray_quad_intersect: drives requests, tolerance writes and output stalls.
// Depends on rqi_pkg, the block and rqi_checker, which predicts and counts mismatches.
`timescale 1ns / 1ps

module tb;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;
  int           errors, pending, hits;
  int           sent = 0;
  int           tol_writes = 0;
  int           hold_left = 0;
  bit           hold_go = 1'b0;
  bit           hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  ray_quad_intersect u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata), .m_tuser_o(m_tuser),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  rqi_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata), .m_tuser_i(m_tuser),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .hits_o(hits)
  );

  function automatic int gap_len();
    if ($urandom_range(9) < 5) return 0;
    if ($urandom_range(19) != 0) return $urandom_range(3);
    return $urandom_range(40, 10);
  endfunction

  // receiver: random stalls, plus one long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= (gap_len() == 0);
      end
    end
  end

  task automatic send(logic [287:0] d, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk_i); while (!s_tready);
    sent++;
  endtask

  task automatic quad(int ox, int oy, int dx, int dy, int c[8]);
    logic [287:0] d;
    d[23:0] = ox[23:0]; d[47:24] = oy[23:0]; d[71:48] = dx[23:0]; d[95:72] = dy[23:0];
    for (int k = 0; k < 8; k++) d[96 + 24 * k +: 24] = c[k][23:0];
    send(d, 1'b0);
  endtask

  task automatic quad_any(int ox, int oy, int dx, int dy, int c[8], bit no_gap);
    logic [287:0] d;
    d[23:0] = ox[23:0]; d[47:24] = oy[23:0]; d[71:48] = dx[23:0]; d[95:72] = dy[23:0];
    for (int k = 0; k < 8; k++) d[96 + 24 * k +: 24] = c[k][23:0];
    send(d, no_gap);
  endtask

  task automatic write_tol(logic [15:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_writes++;
  endtask

  task automatic random_quad(bit no_gap);
    int cx, cy, r, ang, ox, oy, c[8];
    logic [287:0] d;
    if ($urandom_range(9) < 2) begin
      for (int k = 0; k < 9; k++) d[32 * k +: 32] = $urandom();
      send(d, no_gap);
    end else begin
      r  = $urandom_range(5000, 16);
      cx = $urandom_range(40000) - 20000;
      cy = $urandom_range(40000) - 20000;
      c[0] = cx - r + int'($urandom_range(r / 2)); c[1] = cy - r + int'($urandom_range(r / 2));
      c[2] = cx + r - int'($urandom_range(r / 2)); c[3] = cy - r + int'($urandom_range(r / 2));
      c[4] = cx + r - int'($urandom_range(r / 2)); c[5] = cy + r - int'($urandom_range(r / 2));
      c[6] = cx - r + int'($urandom_range(r / 2)); c[7] = cy + r - int'($urandom_range(r / 2));
      if ($urandom_range(1)) begin
        for (int k = 0; k < 2; k++) begin
          ang = c[2 * k]; c[2 * k] = c[6 - 2 * k]; c[6 - 2 * k] = ang;
          ang = c[2 * k + 1]; c[2 * k + 1] = c[7 - 2 * k]; c[7 - 2 * k] = ang;
        end
      end
      ox = cx + int'($urandom_range(6 * r)) - 3 * r;
      oy = cy + int'($urandom_range(6 * r)) - 3 * r;
      quad_any(ox, oy, (cx - ox) * int'($urandom_range(3, 1)) + int'($urandom_range(r)) - r / 2,
               (cy - oy) * int'($urandom_range(3, 1)) + int'($urandom_range(r)) - r / 2,
               c, no_gap);
    end
  endtask

  task automatic directed();
    int sq[8], pt[8], ln[8], mx[8], mn[8];
    sq = '{0, 0, 2560, 0, 2560, 2560, 0, 2560};
    pt = '{300, 300, 300, 300, 300, 300, 300, 300};
    ln = '{0, 0, 1000, 0, 2000, 0, 3000, 0};
    mx = '{8388607, 8388607, -8388608, 8388607, -8388608, -8388608, 8388607, -8388608};
    mn = '{-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608};
    quad(0, 0, 0, 0, '{0, 0, 0, 0, 0, 0, 0, 0});
    quad(-1280, 1280, 5120, 0, sq);
    quad(3840, 1280, -5120, 0, sq);
    quad(1280, -1280, 0, 5120, sq);
    quad(1280, 3840, 0, -5120, sq);
    quad(0, 1280, 5120, 0, sq);
    quad(-2560, 1280, 2560, 0, sq);
    quad(-1280, -1280, 5120, 5120, sq);
    quad(-1280, 2560, 5120, 0, sq);
    quad(-1280, 2561, 5120, 0, sq);
    quad(1280, 1280, 5120, 0, sq);
    quad(-1280, 1280, -5120, 0, sq);
    quad(0, 0, 100, 100, pt);
    quad(500, -500, 0, 2000, ln);
    quad(-8388608, -8388608, 8388607, 8388607, mx);
    quad(8388607, 8388607, -8388608, -8388608, mx);
    quad(8388607, -8388608, 8388607, -8388608, mn);
    quad(-1, -1, -1, -1, '{-1, -1, -1, -1, -1, -1, -1, -1});
    quad(-1280, 1, 5120, 1, sq);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    write_tol(16'd0);
    directed();
    write_tol(16'hFFFF);
    directed();
    for (int k = 0; k < 150; k++) random_quad(1'b0);
    write_tol(16'd0);
    for (int k = 0; k < 150; k++) random_quad(1'b0);
    hold_go = 1'b1;
    for (int k = 0; k < 60; k++) random_quad(1'b1);
    write_tol(16'($urandom_range(65535)));
    for (int k = 0; k < 150; k++) random_quad(1'b0);
    write_tol(16'd1);
    for (int k = 0; k < 100; k++) random_quad(1'b0);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Ran %0d ray-quad requests, %0d with a hit, over %0d tolerance writes.",
             sent, hits, tol_writes);
    $display("Covered axis and diagonal rays, corner ties, degenerate quads and a long stall.");
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule

// ===== sim.f =====
design/rqi_pkg.sv
design/rqi_lane.sv
design/ray_quad_intersect.sv
bench/rqi_checker.sv
bench/tb.sv
